>>> rtl/sle_pkg.sv
// ============================================================================
// sle_pkg - shared types and constants for the sequential list engine
// Widths, opcode and status codes, control struct and search helpers.
// ============================================================================
package sle_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DATA_W = 32;
    localparam int OP_W   = 4;
    localparam int ST_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD   = 4'd0,
        OP_INS_TAIL   = 4'd1,
        OP_INS_POS    = 4'd2,
        OP_INS_SORTED = 4'd3,
        OP_RM_HEAD    = 4'd4,
        OP_RM_TAIL    = 4'd5,
        OP_RM_POS     = 4'd6,
        OP_RM_VALUE   = 4'd7,
        OP_SEARCH     = 4'd8,
        OP_SUM        = 4'd9,
        OP_COUNT      = 4'd10
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic compare;
        logic plan;
        logic apply;
    } t_ctl_cmd;

    function automatic logic [IDX_W-1:0] f_first_set(input logic [DEPTH-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (vec[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

    function automatic logic [IDX_W-1:0] f_last_set(input logic [DEPTH-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (vec[i]) idx = IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

>>> rtl/sle_req_if.sv
// ============================================================================
// sle_req_if - request channel
// Valid/ready channel carrying one list operation per item.
// ============================================================================
interface sle_req_if;
    logic                              valid;
    logic                              ready;
    logic [sle_pkg::OP_W-1:0]          opcode;
    logic signed [sle_pkg::DATA_W-1:0] data_value;
    logic [sle_pkg::CNT_W-1:0]         slot_index;

    modport source (output valid, opcode, data_value, slot_index, input ready);
    modport sink   (input valid, opcode, data_value, slot_index, output ready);
endinterface

>>> rtl/sle_rsp_if.sv
// ============================================================================
// sle_rsp_if - response channel
// Valid/ready channel carrying one result per operation.
// ============================================================================
interface sle_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [sle_pkg::ST_W-1:0]          status;
    logic [sle_pkg::IDX_W-1:0]         found_index;
    logic signed [sle_pkg::DATA_W-1:0] result_value;
    logic [sle_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, status, found_index, result_value, entry_count,
                    input ready);
    modport sink   (input valid, status, found_index, result_value, entry_count,
                    output ready);
endinterface

>>> rtl/sle_ctrl.sv
// ============================================================================
// sle_ctrl - operation sequencer
// Steps each item through load, compare, plan and apply; owns output valid.
// ============================================================================
module sle_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output sle_pkg::t_ctl_cmd o_cmd
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_PLAN  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_APPLY;
            end
            S_APPLY: begin
                if (w_slot_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/sle_dpath.sv
// ============================================================================
// sle_dpath - list storage and datapath
// Row of entry cells with shift and compare, running total and result register.
// ============================================================================
module sle_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sle_pkg::t_ctl_cmd                 i_cmd,
    input  logic [sle_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [sle_pkg::DATA_W-1:0] i_data_value,
    input  logic [sle_pkg::CNT_W-1:0]         i_slot_index,
    output logic [sle_pkg::ST_W-1:0]          o_status,
    output logic [sle_pkg::IDX_W-1:0]         o_found_index,
    output logic signed [sle_pkg::DATA_W-1:0] o_result_value,
    output logic [sle_pkg::CNT_W-1:0]         o_entry_count
);
    import sle_pkg::*;

    logic [DATA_W-1:0] r_entries [DEPTH];
    logic [DATA_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_total;
    t_opcode           r_op;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_slot;
    logic [DEPTH-1:0]  r_eq, r_gt;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic              r_do_ins, n_do_ins;
    logic              r_do_rm, n_do_rm;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_found, n_found;
    logic [DATA_W-1:0] w_sel;
    logic [CNT_W-1:0]  w_count_next;
    logic [DATA_W-1:0] w_total_next;
    logic              w_full, w_empty;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_pos    = '0;
        n_do_ins = 1'b0;
        n_do_rm  = 1'b0;
        n_status = ST_OK;
        n_found  = '0;
        case (r_op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS, OP_INS_SORTED: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (r_op == OP_INS_POS && r_slot > r_count) begin
                    n_status = ST_BADPOS;
                end else begin
                    n_do_ins = 1'b1;
                    case (r_op)
                        OP_INS_HEAD: n_pos = '0;
                        OP_INS_TAIL: n_pos = r_count[IDX_W-1:0];
                        OP_INS_POS:  n_pos = r_slot[IDX_W-1:0];
                        default:     n_pos = (|r_gt) ? f_first_set(r_gt)
                                                     : r_count[IDX_W-1:0];
                    endcase
                end
            end
            OP_RM_HEAD, OP_RM_TAIL, OP_RM_POS, OP_RM_VALUE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_op == OP_RM_POS && r_slot >= r_count) begin
                    n_status = ST_BADPOS;
                end else if (r_op == OP_RM_VALUE && !(|r_eq)) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_do_rm = 1'b1;
                    case (r_op)
                        OP_RM_HEAD: n_pos = '0;
                        OP_RM_TAIL: n_pos = IDX_W'(r_count - CNT_W'(1));
                        OP_RM_POS:  n_pos = r_slot[IDX_W-1:0];
                        default:    n_pos = f_last_set(r_eq);
                    endcase
                end
            end
            OP_SEARCH: begin
                if (|r_eq) begin
                    n_found = f_first_set(r_eq);
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_pos == IDX_W'(i)) w_sel = w_sel | r_entries[i];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (r_do_ins) begin
                if (r_pos == IDX_W'(i))     n_entries[i] = r_val;
                else if (r_pos < IDX_W'(i)) n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
            end else if (r_do_rm) begin
                if (r_pos <= IDX_W'(i) && i < DEPTH - 1)
                    n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        w_count_next = r_count;
        w_total_next = r_total;
        if (r_do_ins) begin
            w_count_next = r_count + CNT_W'(1);
            w_total_next = r_total + r_val;
        end else if (r_do_rm) begin
            w_count_next = r_count - CNT_W'(1);
            w_total_next = r_total - w_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.apply) begin
            r_count <= w_count_next;
            r_total <= w_total_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_opcode'(i_opcode);
            r_val  <= i_data_value;
            r_slot <= i_slot_index;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_eq[i] <= (CNT_W'(i) < r_count) && (r_entries[i] == r_val);
                r_gt[i] <= (CNT_W'(i) < r_count) &&
                           ($signed(r_entries[i]) > $signed(r_val));
            end
        end
        if (i_cmd.plan) begin
            r_pos    <= n_pos;
            r_do_ins <= n_do_ins;
            r_do_rm  <= n_do_rm;
            r_status <= n_status;
            r_found  <= n_found;
        end
        if (i_cmd.apply) begin
            r_entries      <= n_entries;
            o_status       <= r_status;
            o_found_index  <= r_found;
            o_result_value <= (r_op == OP_SUM) ? r_total : '0;
            o_entry_count  <= w_count_next;
        end
    end

endmodule

>>> rtl/sequential_list_engine.sv
// ============================================================================
// sequential_list_engine - packed ordered list of signed 32-bit values
// Insert, remove, search, sum and count over a shift-register list.
// ============================================================================
// Usage:
//   i_req carries one operation per item (opcode, data_value, slot_index).
//   o_rsp returns exactly one item per request with status, found_index,
//   result_value and entry_count.
//   An item is accepted when valid and ready are both high.
//   Each item runs load, compare, plan and apply steps in turn; the result
//   is registered at the apply step, and a new request is taken only once
//   the previous item has left the apply step.
//   The result register is separate from the request side, so a new item is
//   accepted while the previous result still waits. If the receiver stalls,
//   the apply step holds until the result register frees up.
//   Reset empties the list and clears the running sum; no clearing pass.
// ============================================================================
module sequential_list_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sle_req_if.sink    i_req,
    sle_rsp_if.source  o_rsp
);
    import sle_pkg::*;

    t_ctl_cmd w_cmd;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (w_cmd)
    );

    sle_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_opcode       (i_req.opcode),
        .i_data_value   (i_req.data_value),
        .i_slot_index   (i_req.slot_index),
        .o_status       (o_rsp.status),
        .o_found_index  (o_rsp.found_index),
        .o_result_value (o_rsp.result_value),
        .o_entry_count  (o_rsp.entry_count)
    );

endmodule

>>> sim/tb_sequential_list_engine.sv
// ============================================================================
// tb_sequential_list_engine - self-checking testbench for the list engine
// Drives list operations from a queue, predicts each result with a local
// model of the packed list, and compares every result field by field.
// ============================================================================
module tb_sequential_list_engine;
    import sle_pkg::*;

    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic signed [DATA_W-1:0] data_value;
        logic [CNT_W-1:0]         slot_index;
    } t_list_op;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [IDX_W-1:0]  found_index;
        logic [DATA_W-1:0] result_value;
        logic [CNT_W-1:0]  entry_count;
    } t_list_result;

    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    sle_req_if req_ch ();
    sle_rsp_if rsp_ch ();

    sequential_list_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_list_op     pending_ops[$];
    t_list_result expected_results[$];

    logic [DATA_W-1:0] model_entries[DEPTH];
    int                model_fill;
    logic [DATA_W-1:0] model_total;

    int  error_count;
    int  idle_cycles;
    bit  send_hold;
    bit  recv_hold;
    int  recv_hold_cycles;
    bit  no_idle;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [ST_W-1:0] list_insert(int pos, logic [DATA_W-1:0] v);
        if (model_fill >= DEPTH) return ST_FULL;
        if (pos > model_fill) return ST_BADPOS;
        for (int i = model_fill; i > pos; i--) model_entries[i] = model_entries[i-1];
        model_entries[pos] = v;
        model_fill++;
        model_total += v;
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] list_remove(int pos);
        if (model_fill == 0) return ST_EMPTY;
        if (pos >= model_fill) return ST_BADPOS;
        model_total -= model_entries[pos];
        for (int i = pos; i + 1 < model_fill; i++) model_entries[i] = model_entries[i+1];
        model_fill--;
        return ST_OK;
    endfunction

    function automatic t_list_result apply_list_op(t_list_op op);
        t_list_result r;
        int pos;
        bit hit;
        r = '{ST_OK, '0, '0, '0};
        case (op.opcode)
            OP_INS_HEAD:   r.status = list_insert(0, op.data_value);
            OP_INS_TAIL:   r.status = list_insert(model_fill, op.data_value);
            OP_INS_POS:    r.status = list_insert(int'(op.slot_index), op.data_value);
            OP_INS_SORTED: begin
                pos = model_fill;
                for (int i = model_fill - 1; i >= 0; i--)
                    if ($signed(model_entries[i]) > op.data_value) pos = i;
                r.status = list_insert(pos, op.data_value);
            end
            OP_RM_HEAD:    r.status = list_remove(0);
            OP_RM_TAIL:    r.status = (model_fill == 0) ? ST_EMPTY : list_remove(model_fill - 1);
            OP_RM_POS:     r.status = list_remove(int'(op.slot_index));
            OP_RM_VALUE: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    hit = 0;
                    pos = 0;
                    for (int i = 0; i < model_fill; i++)
                        if (model_entries[i] == op.data_value) begin
                            hit = 1;
                            pos = i;
                        end
                    r.status = hit ? list_remove(pos) : ST_NOTFOUND;
                end
            end
            OP_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int i = model_fill - 1; i >= 0; i--)
                    if (model_entries[i] == op.data_value) begin
                        r.status = ST_OK;
                        r.found_index = IDX_W'(i);
                    end
            end
            OP_SUM:        r.result_value = model_total;
            default: ;
        endcase
        r.entry_count = CNT_W'(model_fill);
        return r;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] opc, logic [DATA_W-1:0] v, int slot);
        t_list_op op;
        op.opcode = opc;
        op.data_value = v;
        op.slot_index = CNT_W'(slot);
        pending_ops.push_back(op);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom;
            default: return DATA_W'($urandom_range(0, 15)) - 32'd8;
        endcase
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.opcode <= '0;
            req_ch.data_value <= '0;
            req_ch.slot_index <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_ops.size() > 0 && !send_hold &&
                (no_idle || $urandom_range(0, 99) >= 18)) begin
                t_list_op op;
                op = pending_ops.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.opcode <= op.opcode;
                req_ch.data_value <= op.data_value;
                req_ch.slot_index <= op.slot_index;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Prediction on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_list_op op;
            op.opcode = req_ch.opcode;
            op.data_value = req_ch.data_value;
            op.slot_index = req_ch.slot_index;
            expected_results.push_back(apply_list_op(op));
        end
    end

    // Receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_hold_cycles <= 0;
        end else if (recv_hold) begin
            rsp_ch.ready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles + 1;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 18);
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d count=%0d", $time,
                         rsp_ch.status, rsp_ch.entry_count);
                error_count++;
            end else begin
                t_list_result e;
                e = expected_results.pop_front();
                if (rsp_ch.status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.found_index !== e.found_index) begin
                    $display("%0t: found_index expected %0d actual %0d", $time,
                             e.found_index, rsp_ch.found_index);
                    error_count++;
                end
                if (rsp_ch.result_value !== e.result_value) begin
                    $display("%0t: result_value expected %0h actual %0h", $time,
                             e.result_value, rsp_ch.result_value);
                    error_count++;
                end
                if (rsp_ch.entry_count !== e.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             e.entry_count, rsp_ch.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n ||
            recv_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("sequential_list_engine verification failed");
            $finish;
        end
    end

    initial begin
        int opc;
        int burst;
        error_count = 0;
        idle_cycles = 0;
        send_hold = 0;
        recv_hold = 0;
        no_idle = 0;
        model_fill = 0;
        model_total = '0;
        foreach (model_entries[i]) model_entries[i] = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = '0;
        req_ch.data_value = '0;
        req_ch.slot_index = '0;
        rsp_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-list cases, extremes, every opcode
        queue_op(OP_RM_HEAD, 0, 0);
        queue_op(OP_RM_TAIL, 0, 0);
        queue_op(OP_RM_POS, 0, 0);
        queue_op(OP_RM_VALUE, 5, 0);
        queue_op(OP_SEARCH, 5, 0);
        queue_op(OP_SUM, 0, 0);
        queue_op(OP_INS_POS, 1, 1);
        queue_op(OP_INS_HEAD, 32'h7fff_ffff, 0);
        queue_op(OP_INS_TAIL, 32'h8000_0000, 0);
        queue_op(OP_INS_POS, 32'hffff_ffff, 2);
        queue_op(OP_INS_SORTED, 0, 0);
        queue_op(OP_INS_SORTED, 0, 0);
        queue_op(OP_SEARCH, 0, 0);
        queue_op(OP_SUM, 0, 0);
        queue_op(OP_COUNT, 0, 0);
        queue_op(OP_RM_POS, 0, 5);
        queue_op(OP_RM_POS, 0, 127);
        queue_op(OP_RM_VALUE, 0, 0);
        queue_op(OP_RM_VALUE, 77, 0);
        queue_op(4'd11, 32'h5a5a_5a5a, 127);
        queue_op(4'd15, 32'ha5a5_a5a5, 64);
        queue_op(OP_RM_POS, 0, 1);
        queue_op(OP_RM_TAIL, 0, 0);
        queue_op(OP_RM_HEAD, 0, 0);

        // Random: alternating fill and drain phases so the list reaches full and empty
        for (int n = 0; n < 1620; n++) begin
            burst = (n / 200) % 2;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: opc = (burst == 0) ? $urandom_range(0, 3) : $urandom_range(4, 7);
                4, 5: opc = $urandom_range(0, 7);
                6: opc = OP_SEARCH;
                7: opc = $urandom_range(9, 10);
                8: opc = $urandom_range(0, 15);
                default: opc = (burst == 0) ? OP_INS_SORTED : OP_RM_VALUE;
            endcase
            queue_op(OP_W'(opc), rand_value(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 66));
            if (n == 500) begin
                wait (pending_ops.size() == 0);
                recv_hold = 1;
                for (int k = 0; k < 30; k++) queue_op(OP_COUNT, 0, 0);
                wait (recv_hold_cycles >= 200);
                recv_hold = 0;
            end
            if (n == 900) begin
                wait (pending_ops.size() == 0);
                send_hold = 1;
                wait (expected_results.size() == 0 && !req_ch.valid);
                send_hold = 0;
            end
            if (n == 1100) begin
                wait (pending_ops.size() == 0);
                no_idle = 1;
            end
            if (n == 1400) begin
                wait (pending_ops.size() == 0);
                no_idle = 0;
            end
        end
        wait (pending_ops.size() == 0 && !req_ch.valid && expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("sequential_list_engine verification clean");
        else
            $display("sequential_list_engine verification failed");
        $finish;
    end
endmodule
